// File: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHK_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define CHK_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/detcc_pkg.sv
// ----------------------------------------------------------------------------
// detcc_pkg
// Types, codes and constants of the edge table with cycle check.
// ----------------------------------------------------------------------------
package detcc_pkg;

    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 64;

    localparam int CNT_W     = 7;
    localparam int ID_W      = 6;
    localparam int KIND_W    = 4;
    localparam int PORT_W    = 4;
    localparam int TYPE_W    = 2;
    localparam int STAT_W    = 3;
    localparam int CMD_W     = 3;
    localparam int EDGE_W    = 24;
    localparam int MAP_W     = 64;
    localparam int IN_W      = 37;
    localparam int S_TDATA_W = 40;
    localparam int OUT_W     = 26;
    localparam int M_TDATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_ADD_NODE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RGB      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_KEY      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CHAN     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_TERMINAL = 3'd6;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_CYCLE    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NONE     = 3'd4;

    localparam logic [TYPE_W-1:0] PIPE_RGB  = 2'd0;
    localparam logic [TYPE_W-1:0] PIPE_KEY  = 2'd1;
    localparam logic [TYPE_W-1:0] PIPE_CHAN = 2'd2;

    localparam logic [1:0] IX_ZERO = 2'd0;
    localparam logic [1:0] IX_NODE = 2'd1;
    localparam logic [1:0] IX_EDGE = 2'd2;
    localparam logic [1:0] IX_SCAN = 2'd3;

    localparam logic [1:0] SS_NONE = 2'd0;
    localparam logic [1:0] SS_EDGE = 2'd1;
    localparam logic [1:0] SS_PEND = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   query_node;
        logic [PORT_W-1:0] to_port;
        logic [TYPE_W-1:0] to_type;
        logic [ID_W-1:0]   to_node;
        logic [PORT_W-1:0] from_port;
        logic [TYPE_W-1:0] from_type;
        logic [ID_W-1:0]   from_node;
        logic [KIND_W-1:0] node_kind;
        logic [CMD_W-1:0]  command;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0]  node_count;
        logic [ID_W-1:0]   source_node;
        logic [PORT_W-1:0] source_port;
        logic [ID_W-1:0]   result_index;
        logic [STAT_W-1:0] status;
    } res_t;

    typedef struct packed {
        logic              latch_item;
        logic              node_add;
        logic              edge_add;
        logic              edge_dec;
        logic              tbl_clear;
        logic              idx_clear;
        logic              idx_inc;
        logic              rd_edge;
        logic              rd_node;
        logic              walk_init;
        logic              walk_acc;
        logic              walk_step;
        logic              shift_wr;
        logic              pend_set;
        logic              pend_clr;
        logic              out_load;
        logic [STAT_W-1:0] out_status;
        logic [1:0]        idx_sel;
        logic [1:0]        src_sel;
        logic              out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             node_full;
        logic             edge_full;
        logic             edge_end;
        logic             node_end;
        logic             target_hit;
        logic             frontier_zero;
        logic             edge_match;
        logic             rgb_match;
        logic             src_match;
        logic             kind_match;
        logic             pend_valid;
        logic             out_free;
    } dp_stat_t;

endpackage

// File: design/detcc_ram.sv
// ----------------------------------------------------------------------------
// detcc_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module detcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/detcc_ctrl.sv
// ----------------------------------------------------------------------------
// detcc_ctrl
// Command sequencer: dispatch, reachability walk, table sweeps and result
// issue.
// ----------------------------------------------------------------------------
module detcc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  detcc_pkg::dp_stat_t stat,
    output detcc_pkg::dp_cmd_t  cmd
);

    import detcc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_W_TEST = 4'd2;
    localparam logic [3:0] S_W_RD   = 4'd3;
    localparam logic [3:0] S_W_EV   = 4'd4;
    localparam logic [3:0] S_R_RD   = 4'd5;
    localparam logic [3:0] S_R_EV   = 4'd6;
    localparam logic [3:0] S_C_RD   = 4'd7;
    localparam logic [3:0] S_C_WR   = 4'd8;
    localparam logic [3:0] S_Q_RD   = 4'd9;
    localparam logic [3:0] S_Q_EV   = 4'd10;
    localparam logic [3:0] S_T_RD   = 4'd11;
    localparam logic [3:0] S_T_EV   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    function automatic dp_cmd_t emit(input dp_cmd_t c, input logic [STAT_W-1:0] st,
                                     input logic [1:0] isel, input logic [1:0] ssel,
                                     input logic last);
        dp_cmd_t r;
        r            = c;
        r.out_load   = 1'b1;
        r.out_status = st;
        r.idx_sel    = isel;
        r.src_sel    = ssel;
        r.out_last   = last;
        return r;
    endfunction

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.command) inside
                    CMD_ADD_NODE:
                    begin
                        if (stat.out_free)
                        begin
                            if (stat.node_full)
                            begin
                                cmd = emit(cmd, ST_FULL, IX_ZERO, SS_NONE, 1'b1);
                            end
                            else
                            begin
                                cmd.node_add = 1'b1;
                                cmd = emit(cmd, ST_OK, IX_NODE, SS_NONE, 1'b1);
                            end
                            state_next = S_IDLE;
                        end
                    end
                    CMD_ADD_EDGE:
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = S_W_TEST;
                    end
                    CMD_REMOVE:
                    begin
                        cmd.idx_clear = 1'b1;
                        state_next    = S_R_RD;
                    end
                    CMD_RGB, CMD_KEY, CMD_CHAN:
                    begin
                        cmd.idx_clear = 1'b1;
                        cmd.pend_clr  = 1'b1;
                        state_next    = S_Q_RD;
                    end
                    CMD_TERMINAL:
                    begin
                        cmd.idx_clear = 1'b1;
                        state_next    = S_T_RD;
                    end
                    default:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.tbl_clear = 1'b1;
                            cmd = emit(cmd, ST_OK, IX_ZERO, SS_NONE, 1'b1);
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_W_TEST:
            begin
                if (stat.target_hit || stat.frontier_zero)
                begin
                    if (stat.out_free)
                    begin
                        if (stat.target_hit)
                        begin
                            cmd = emit(cmd, ST_CYCLE, IX_ZERO, SS_NONE, 1'b1);
                        end
                        else if (stat.edge_full)
                        begin
                            cmd = emit(cmd, ST_FULL, IX_ZERO, SS_NONE, 1'b1);
                        end
                        else
                        begin
                            cmd.edge_add = 1'b1;
                            cmd = emit(cmd, ST_OK, IX_EDGE, SS_NONE, 1'b1);
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = S_W_RD;
                end
            end
            S_W_RD:
            begin
                if (stat.edge_end)
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_W_TEST;
                end
                else
                begin
                    cmd.rd_edge = 1'b1;
                    state_next  = S_W_EV;
                end
            end
            S_W_EV:
            begin
                cmd.walk_acc = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_W_RD;
            end
            S_R_RD:
            begin
                if (stat.edge_end)
                begin
                    if (stat.out_free)
                    begin
                        cmd = emit(cmd, ST_NOTFOUND, IX_ZERO, SS_NONE, 1'b1);
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_edge = 1'b1;
                    state_next  = S_R_EV;
                end
            end
            S_R_EV:
            begin
                cmd.idx_inc = 1'b1;
                state_next  = stat.edge_match ? S_C_RD : S_R_RD;
            end
            S_C_RD:
            begin
                if (stat.edge_end)
                begin
                    if (stat.out_free)
                    begin
                        cmd.edge_dec = 1'b1;
                        cmd = emit(cmd, ST_OK, IX_ZERO, SS_NONE, 1'b1);
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_edge = 1'b1;
                    state_next  = S_C_WR;
                end
            end
            S_C_WR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_C_RD;
            end
            S_Q_RD:
            begin
                if (stat.edge_end)
                begin
                    if (stat.out_free)
                    begin
                        if ((stat.command != CMD_RGB) && stat.pend_valid)
                        begin
                            cmd = emit(cmd, ST_OK, IX_ZERO, SS_PEND, 1'b1);
                        end
                        else
                        begin
                            cmd = emit(cmd, ST_NONE, IX_ZERO, SS_NONE, 1'b1);
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_edge = 1'b1;
                    state_next  = S_Q_EV;
                end
            end
            S_Q_EV:
            begin
                if (stat.command == CMD_RGB)
                begin
                    if (stat.rgb_match)
                    begin
                        if (stat.out_free)
                        begin
                            cmd = emit(cmd, ST_OK, IX_ZERO, SS_EDGE, 1'b1);
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_Q_RD;
                    end
                end
                else if (!(stat.src_match && stat.pend_valid && !stat.out_free))
                begin
                    if (stat.src_match)
                    begin
                        cmd.pend_set = 1'b1;
                        if (stat.pend_valid)
                        begin
                            cmd = emit(cmd, ST_OK, IX_ZERO, SS_PEND, 1'b0);
                        end
                    end
                    cmd.idx_inc = 1'b1;
                    state_next  = S_Q_RD;
                end
            end
            S_T_RD:
            begin
                if (stat.node_end)
                begin
                    if (stat.out_free)
                    begin
                        cmd = emit(cmd, ST_NONE, IX_ZERO, SS_NONE, 1'b1);
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_node = 1'b1;
                    state_next  = S_T_EV;
                end
            end
            S_T_EV:
            begin
                if (stat.kind_match)
                begin
                    if (stat.out_free)
                    begin
                        cmd = emit(cmd, ST_OK, IX_SCAN, SS_NONE, 1'b1);
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_T_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/detcc_dp.sv
// ----------------------------------------------------------------------------
// detcc_dp
// Datapath: node and edge tables, counters, reachability maps and the
// output register.
// ----------------------------------------------------------------------------
module detcc_dp #(
    parameter int MAX_NODES = detcc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = detcc_pkg::DEF_MAX_EDGES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [detcc_pkg::KIND_W-1:0]  cfg_wdata,
    input  detcc_pkg::item_t              in_item,
    input  detcc_pkg::dp_cmd_t            cmd,
    output detcc_pkg::dp_stat_t           stat,
    input  logic                          m_tready,
    output logic                          out_valid,
    output detcc_pkg::res_t               out_res,
    output logic                          out_last
);

    import detcc_pkg::*;

    localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    item_t             item_reg;
    logic [KIND_W-1:0] output_kind_reg;
    logic [CNT_W-1:0]  node_total_reg;
    logic [CNT_W-1:0]  node_total_next;
    logic [CNT_W-1:0]  edge_total_reg;
    logic [CNT_W-1:0]  edge_total_next;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  shift_idx;
    logic [MAP_W-1:0]  visited_reg;
    logic [MAP_W-1:0]  frontier_reg;
    logic [MAP_W-1:0]  next_reg;
    logic              pend_valid_reg;
    logic [PORT_W-1:0] pend_port_reg;
    logic [ID_W-1:0]   pend_node_reg;
    logic              out_valid_reg;
    res_t              out_res_reg;
    logic              out_last_reg;

    logic [EDGE_W-1:0] edge_word;
    logic [EDGE_W-1:0] edge_rdata;
    logic [KIND_W-1:0] node_rdata;
    logic              edge_we;
    logic [EAW-1:0]    edge_waddr;
    logic [EDGE_W-1:0] edge_wdata;
    logic [ID_W-1:0]   rd_fn;
    logic [ID_W-1:0]   rd_tn;
    logic [TYPE_W-1:0] rd_tt;
    logic [PORT_W-1:0] rd_tp;
    logic [TYPE_W-1:0] want_type;
    logic              out_free;
    res_t              res_new;

    assign edge_word = {item_reg.from_node, item_reg.from_type, item_reg.from_port,
                        item_reg.to_node, item_reg.to_type, item_reg.to_port};
    assign rd_fn     = edge_rdata[23:18];
    assign rd_tn     = edge_rdata[11:6];
    assign rd_tt     = edge_rdata[5:4];
    assign rd_tp     = edge_rdata[3:0];
    assign shift_idx = idx_reg - CNT_W'(1);
    assign want_type = (item_reg.command == CMD_KEY) ? PIPE_KEY : PIPE_CHAN;

    // table writes
    assign edge_we    = cmd.edge_add || cmd.shift_wr;
    assign edge_waddr = cmd.shift_wr ? shift_idx[EAW-1:0] : edge_total_reg[EAW-1:0];
    assign edge_wdata = cmd.shift_wr ? edge_rdata : edge_word;

    detcc_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (cmd.rd_edge),
        .raddr (idx_reg[EAW-1:0]),
        .rdata (edge_rdata)
    );

    detcc_ram #(
        .WIDTH (KIND_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (cmd.node_add),
        .waddr (node_total_reg[NAW-1:0]),
        .wdata (item_reg.node_kind),
        .re    (cmd.rd_node),
        .raddr (idx_reg[NAW-1:0]),
        .rdata (node_rdata)
    );

    always_comb
    begin
        node_total_next = node_total_reg;
        if (cmd.tbl_clear)
        begin
            node_total_next = '0;
        end
        else if (cmd.node_add)
        begin
            node_total_next = node_total_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        edge_total_next = edge_total_reg;
        if (cmd.tbl_clear)
        begin
            edge_total_next = '0;
        end
        else if (cmd.edge_add)
        begin
            edge_total_next = edge_total_reg + CNT_W'(1);
        end
        else if (cmd.edge_dec)
        begin
            edge_total_next = edge_total_reg - CNT_W'(1);
        end
    end

    // result assembly
    always_comb
    begin
        res_new            = '0;
        res_new.status     = cmd.out_status;
        res_new.node_count = node_total_next;
        case (cmd.idx_sel)
            IX_NODE: res_new.result_index = node_total_reg[ID_W-1:0];
            IX_EDGE: res_new.result_index = edge_total_reg[ID_W-1:0];
            IX_SCAN: res_new.result_index = idx_reg[ID_W-1:0];
            default: res_new.result_index = '0;
        endcase
        case (cmd.src_sel)
            SS_EDGE:
            begin
                res_new.source_node = rd_fn;
            end
            SS_PEND:
            begin
                res_new.source_node = pend_node_reg;
                res_new.source_port = pend_port_reg;
            end
            default:
            begin
                res_new.source_node = '0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        stat               = '0;
        stat.command       = item_reg.command;
        stat.node_full     = node_total_reg >= CNT_W'(MAX_NODES);
        stat.edge_full     = edge_total_reg >= CNT_W'(MAX_EDGES);
        stat.edge_end      = idx_reg >= edge_total_reg;
        stat.node_end      = idx_reg >= node_total_reg;
        stat.target_hit    = frontier_reg[item_reg.from_node];
        stat.frontier_zero = (frontier_reg == '0);
        stat.edge_match    = (edge_rdata == edge_word);
        stat.rgb_match     = (rd_tn == item_reg.query_node) && (rd_tt == PIPE_RGB);
        stat.src_match     = (rd_tn == item_reg.query_node) && (rd_tt == want_type);
        stat.kind_match    = (node_rdata == output_kind_reg);
        stat.pend_valid    = pend_valid_reg;
        stat.out_free      = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_kind_reg <= '0;
            node_total_reg  <= '0;
            edge_total_reg  <= '0;
            idx_reg         <= '0;
            visited_reg     <= '0;
            frontier_reg    <= '0;
            next_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                output_kind_reg <= cfg_wdata;
            end
            node_total_reg <= node_total_next;
            edge_total_reg <= edge_total_next;
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (cmd.walk_init)
            begin
                visited_reg  <= '0;
                frontier_reg <= MAP_W'(1) << item_reg.to_node;
                next_reg     <= '0;
            end
            else if (cmd.walk_step)
            begin
                visited_reg  <= visited_reg | frontier_reg;
                frontier_reg <= next_reg & ~(visited_reg | frontier_reg);
                next_reg     <= '0;
            end
            else if (cmd.walk_acc && frontier_reg[rd_fn])
            begin
                next_reg <= next_reg | (MAP_W'(1) << rd_tn);
            end
            if (cmd.pend_clr)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.pend_set)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_reg <= in_item;
        end
        if (cmd.pend_set)
        begin
            pend_port_reg <= rd_tp;
            pend_node_reg <= rd_fn;
        end
        if (cmd.out_load)
        begin
            out_res_reg  <= res_new;
            out_last_reg <= cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;

endmodule

// File: design/dag_edge_table_cycle_check.sv
// ----------------------------------------------------------------------------
// dag_edge_table_cycle_check
// Node and edge tables of a pipe graph, with a reachability check that keeps
// the graph free of cycles.
// ----------------------------------------------------------------------------
// One transaction is taken at a time; s_tready is low until its last result
// has been loaded into the output register. Remove, source queries and
// terminal lookup sweep the edge or node table, with one RAM read and one
// evaluate for each entry visited. Add edge runs a breadth-first walk that
// sweeps the edge table once per step, with as many steps as the walk's depth
// plus one. A stalled m_tready holds the sequencer only when it has a further
// result to issue.
module dag_edge_table_cycle_check #(
    parameter int MAX_NODES = detcc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = detcc_pkg::DEF_MAX_EDGES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [detcc_pkg::KIND_W-1:0]     cfg_wdata,    // output_kind
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // command, node_kind, from_node, from_type, from_port, to_node, to_type,
    // to_port, query_node
    input  logic [detcc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status, result_index, source_port, source_node, node_count
    output logic [detcc_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast
);

    import detcc_pkg::*;

    item_t    in_item;
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    res_t     out_res;

    assign in_item = item_t'(s_tdata[IN_W-1:0]);

    detcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    detcc_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_item),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .m_tready  (m_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W - OUT_W){1'b0}}, out_res};

endmodule

// File: design/detcc_checker.sv
// ----------------------------------------------------------------------------
// detcc_checker
// Port level checks of the edge table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module detcc_checker #(
    parameter int MAX_NODES = detcc_pkg::DEF_MAX_NODES
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [detcc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast
);

    import detcc_pkg::*;

    `CHK_NEXT(a_accept_busy, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `CHK_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `CHK_IMPLY(a_more_ok, clk, rst_n, m_tvalid && !m_tlast, m_tdata[2:0] == ST_OK)
    `CHK_IMPLY(a_count_max, clk, rst_n, m_tvalid, m_tdata[25:19] <= CNT_W'(MAX_NODES))

endmodule

bind dag_edge_table_cycle_check detcc_checker #(
    .MAX_NODES (MAX_NODES)
) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
